[rtl/core/sfla_pkg.sv]
// Package for the slab free-list allocator: word types, codes, command and
// status structs shared by controller and datapath. No dependencies.
package sfla_pkg;

    localparam int DEF_PAGE_BYTES  = 4096;
    localparam int DEF_STORE_DEPTH = 1024;
    localparam int DEF_ADDR_BITS   = 32;
    localparam int DEF_MIN_ENTRY   = 8;

    localparam int ES_W       = 13;
    localparam int HDR_W      = 12;
    localparam int WORD_ADDR_W = 32;
    localparam int FREE_W     = 11;
    localparam int TOTAL_W    = 32;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = ES_W;

    localparam logic [ES_W-1:0]  ES_RESET  = ES_W'(16);
    localparam logic [HDR_W-1:0] HDR_RESET = HDR_W'(32);

    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_SIZE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        FUNC_START = 2'd0,
        FUNC_ALLOC = 2'd1,
        FUNC_FREE  = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_SMALL   = 3'd1,
        ST_FULL    = 3'd2,
        ST_NOFIT   = 3'd3,
        ST_NOSTART = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_CARVE,
        S_POP,
        S_RESP
    } state_t;

    typedef struct packed {
        func_t                  func;
        logic [WORD_ADDR_W-1:0] page_base;
        logic [WORD_ADDR_W-1:0] entry_address;
    } req_t;

    typedef struct packed {
        status_t                status;
        logic [WORD_ADDR_W-1:0] alloc_address;
        logic [FREE_W-1:0]      free_entries;
        logic [TOTAL_W-1:0]     total_entries;
    } rsp_t;

    typedef struct packed {
        logic    capture;
        logic    start_init;
        logic    refill_init;
        logic    carve_step;
        logic    carve_drop;
        logic    pop;
        logic    push;
        logic    set_status;
        status_t status;
        logic    load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        func_t func;
        logic  es_small;
        logic  started;
        logic  count_zero;
        logic  count_full;
        logic  carve_fits;
        logic  dropped;
        logic  out_space;
    } dp_status_t;

endpackage

[rtl/core/sfla_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sfla_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/sfla_ctrl.sv]
// Controller state machine for the slab free-list allocator.
// Depends on sfla_pkg; drives datapath commands from datapath status.
module sfla_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  sfla_pkg::dp_status_t   sts,
    output sfla_pkg::ctrl_cmd_t    cmd
);

    import sfla_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   drop_now;

    assign drop_now = sts.carve_fits && sts.count_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_RESP;
                if (sts.func == FUNC_START && !sts.es_small)
                begin
                    state_next = S_CARVE;
                end
                else if (sts.func == FUNC_ALLOC && sts.started && sts.count_zero)
                begin
                    state_next = S_CARVE;
                end
            end
            S_CARVE:
            begin
                if (!sts.carve_fits || sts.count_full)
                begin
                    state_next = (sts.func == FUNC_START) ? S_RESP : S_POP;
                end
            end
            S_POP:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (sts.out_space)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
            end
            S_DECODE:
            begin
                cmd.set_status = 1'b1;
                cmd.status     = ST_OK;
                case (sts.func)
                    FUNC_START:
                    begin
                        if (sts.es_small)
                        begin
                            cmd.status = ST_SMALL;
                        end
                        else
                        begin
                            cmd.start_init = 1'b1;
                        end
                    end
                    FUNC_ALLOC:
                    begin
                        if (!sts.started)
                        begin
                            cmd.status = ST_NOSTART;
                        end
                        else if (sts.count_zero)
                        begin
                            cmd.refill_init = 1'b1;
                        end
                        else
                        begin
                            cmd.pop = 1'b1;
                        end
                    end
                    FUNC_FREE:
                    begin
                        if (!sts.started)
                        begin
                            cmd.status = ST_NOSTART;
                        end
                        else if (sts.count_full)
                        begin
                            cmd.status = ST_FULL;
                        end
                        else
                        begin
                            cmd.push = 1'b1;
                        end
                    end
                    default:
                    begin
                        cmd.status = ST_OK;
                    end
                endcase
            end
            S_CARVE:
            begin
                cmd.carve_step = sts.carve_fits && !sts.count_full;
                cmd.carve_drop = drop_now;
                if (sts.func == FUNC_START && (!sts.carve_fits || sts.count_full))
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = drop_now ? ST_FULL : ST_OK;
                end
            end
            S_POP:
            begin
                cmd.set_status = 1'b1;
                if (sts.count_zero)
                begin
                    cmd.status = ST_NOFIT;
                end
                else
                begin
                    cmd.pop    = 1'b1;
                    cmd.status = sts.dropped ? ST_FULL : ST_OK;
                end
            end
            S_RESP:
            begin
                cmd.load_out = sts.out_space;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

`ifndef SYNTH
    a_carve_started: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CARVE |-> sts.started)
        else $error("carving while not started");

    a_carve_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.carve_step |-> sts.carve_fits && !sts.count_full)
        else $error("carve step without room");

    a_load_space: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> state_reg == S_IDLE)
        else $error("result load did not return to idle");
`endif

endmodule

[rtl/core/sfla_dpath.sv]
// Datapath of the slab free-list allocator: config, list pointers, carving
// counters, free store RAM and result register. Depends on sfla_pkg, sfla_ram.
module sfla_dpath #(
    parameter int PAGE_BYTES  = sfla_pkg::DEF_PAGE_BYTES,
    parameter int STORE_DEPTH = sfla_pkg::DEF_STORE_DEPTH,
    parameter int ADDR_BITS   = sfla_pkg::DEF_ADDR_BITS,
    parameter int MIN_ENTRY   = sfla_pkg::DEF_MIN_ENTRY
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sfla_pkg::req_t                    req,
    input  logic                              cfg_valid,
    input  logic [sfla_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sfla_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              rsp_ready,
    input  sfla_pkg::ctrl_cmd_t               cmd,
    output sfla_pkg::dp_status_t              sts,
    output sfla_pkg::rsp_t                    rsp,
    output logic                              rsp_valid
);

    import sfla_pkg::*;

    localparam int IW     = $clog2(STORE_DEPTH);
    localparam int CW     = $clog2(STORE_DEPTH + 1);
    localparam int OFF_W  = $clog2(PAGE_BYTES + (1 << ES_W));
    localparam int OFF_W1 = OFF_W + 1;
    localparam logic [IW-1:0]    LAST_IDX = IW'(STORE_DEPTH - 1);
    localparam logic [CW-1:0]    FULL_CNT = CW'(STORE_DEPTH);
    localparam logic [OFF_W-1:0] PAGE_LEN = OFF_W'(PAGE_BYTES);
    localparam logic [ES_W-1:0]  MIN_ES   = ES_W'(MIN_ENTRY);

    logic [ES_W-1:0]        es_reg, es_next;
    logic [HDR_W-1:0]       hdr_reg, hdr_next;
    func_t                  func_reg, func_next;
    logic [WORD_ADDR_W-1:0] page_reg, page_next;
    logic [WORD_ADDR_W-1:0] ent_reg, ent_next;
    logic [IW-1:0]          front_reg, front_next;
    logic [IW-1:0]          tail_reg, tail_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [TOTAL_W-1:0]     total_reg, total_next;
    logic                   started_reg, started_next;
    logic                   dropped_reg, dropped_next;
    logic                   give_reg, give_next;
    status_t                status_reg, status_next;
    logic [OFF_W-1:0]       off_reg, off_next;
    logic [OFF_W-1:0]       len_reg, len_next;
    logic [ADDR_BITS-1:0]   cur_reg, cur_next;
    rsp_t                   rsp_reg, rsp_next;
    logic                   rsp_valid_reg, rsp_valid_next;

    logic [IW-1:0]          front_inc, front_dec, tail_inc;
    logic                   fits;
    logic                   mem_we;
    logic [IW-1:0]          mem_waddr;
    logic [ADDR_BITS-1:0]   mem_wdata;
    logic [ADDR_BITS-1:0]   mem_rdata;

    assign front_inc = (front_reg == LAST_IDX) ? '0 : front_reg + 1'b1;
    assign front_dec = (front_reg == '0) ? LAST_IDX : front_reg - 1'b1;
    assign tail_inc  = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
    assign fits      = (es_reg != '0)
                    && (OFF_W1'(off_reg) + OFF_W1'(es_reg) <= OFF_W1'(len_reg));

    assign mem_we    = cmd.carve_step || cmd.push;
    assign mem_waddr = cmd.push ? front_dec : tail_reg;
    assign mem_wdata = cmd.push ? ADDR_BITS'(ent_reg) : cur_reg;

    sfla_ram #(
        .WIDTH (ADDR_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (cmd.pop),
        .raddr (front_reg),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        es_next        = es_reg;
        hdr_next       = hdr_reg;
        func_next      = func_reg;
        page_next      = page_reg;
        ent_next       = ent_reg;
        front_next     = front_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        started_next   = started_reg;
        dropped_next   = dropped_reg;
        give_next      = give_reg;
        status_next    = status_reg;
        off_next       = off_reg;
        len_next       = len_reg;
        cur_next       = cur_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ENTRY_SIZE:   es_next  = cfg_data[ES_W-1:0];
                CFG_HEADER_BYTES: hdr_next = cfg_data[HDR_W-1:0];
                default:          es_next  = es_reg;
            endcase
        end

        if (cmd.capture)
        begin
            func_next    = req.func;
            page_next    = req.page_base;
            ent_next     = req.entry_address;
            dropped_next = 1'b0;
            give_next    = 1'b0;
        end

        if (cmd.start_init)
        begin
            front_next   = '0;
            tail_next    = '0;
            count_next   = '0;
            total_next   = '0;
            started_next = 1'b1;
            off_next     = '0;
            len_next     = (OFF_W'(hdr_reg) < PAGE_LEN) ? PAGE_LEN - OFF_W'(hdr_reg) : '0;
            cur_next     = ADDR_BITS'(page_reg) + ADDR_BITS'(hdr_reg);
        end

        if (cmd.refill_init)
        begin
            off_next = '0;
            len_next = PAGE_LEN;
            cur_next = ADDR_BITS'(page_reg);
        end

        if (cmd.carve_step)
        begin
            tail_next  = tail_inc;
            count_next = count_reg + 1'b1;
            total_next = total_reg + 1'b1;
            off_next   = off_reg + OFF_W'(es_reg);
            cur_next   = cur_reg + ADDR_BITS'(es_reg);
        end

        if (cmd.carve_drop)
        begin
            dropped_next = 1'b1;
        end

        if (cmd.pop)
        begin
            front_next = front_inc;
            count_next = count_reg - 1'b1;
            give_next  = 1'b1;
        end

        if (cmd.push)
        begin
            front_next = front_dec;
            count_next = count_reg + 1'b1;
        end

        if (cmd.set_status)
        begin
            status_next = cmd.status;
        end

        if (cmd.load_out)
        begin
            rsp_valid_next         = 1'b1;
            rsp_next.status        = status_reg;
            rsp_next.alloc_address = give_reg ? WORD_ADDR_W'(mem_rdata) : '0;
            rsp_next.free_entries  = FREE_W'(count_reg);
            rsp_next.total_entries = total_reg;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            es_reg        <= ES_RESET;
            hdr_reg       <= HDR_RESET;
            front_reg     <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            total_reg     <= '0;
            started_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            es_reg        <= es_next;
            hdr_reg       <= hdr_next;
            front_reg     <= front_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            started_reg   <= started_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        page_reg    <= page_next;
        ent_reg     <= ent_next;
        dropped_reg <= dropped_next;
        give_reg    <= give_next;
        status_reg  <= status_next;
        off_reg     <= off_next;
        len_reg     <= len_next;
        cur_reg     <= cur_next;
        rsp_reg     <= rsp_next;
    end

    always_comb
    begin
        sts.func       = func_reg;
        sts.es_small   = es_reg < MIN_ES;
        sts.started    = started_reg;
        sts.count_zero = count_reg == '0;
        sts.count_full = count_reg == FULL_CNT;
        sts.carve_fits = fits;
        sts.dropped    = dropped_reg;
        sts.out_space  = !rsp_valid_reg || rsp_ready;
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

`ifndef SYNTH
    a_ring_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(front_reg) + int'(count_reg) == int'(tail_reg))
        || (int'(front_reg) + int'(count_reg) == int'(tail_reg) + STORE_DEPTH))
        else $error("tail pointer out of step with front and count");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |=> count_reg == $past(count_reg) + 1'b1)
        else $error("push did not grow the list");

    a_pop_give: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |=> give_reg && count_reg == $past(count_reg) - 1'b1)
        else $error("pop did not shrink the list");
`endif

endmodule

[rtl/core/slab_free_list_allocator.sv]
// Slab free-list allocator: bounded free list of fixed-size entry addresses.
// Request channel (req_valid/req_ready, req word): func 0 starts with a first
// page, func 1 allocates, func 2 frees an entry, func 3 does nothing.
// Response channel (rsp_valid/rsp_ready, rsp word): one word per request with
// status, handed-out address, free count and carved total.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 entry
// size, index 1 header bytes; write only while idle. Always ready.
// Alloc (list not empty), free, nop and refused requests pass from decode
// straight to the response state; the next request is taken only once the
// response word is loaded and the controller is back in idle.
// Start, and alloc on an empty list, carve one entry per cycle through the
// single write port of the free store, up to PAGE_BYTES / entry_size entries
// and no more than the store holds; an alloc then pops in the pop state.
// Reset clears list pointers, counts and the started flag and restores
// entry size 16, header 32; the store itself is not cleared, no sweep needed.
// A stalled receiver leaves the word in the output register; one further
// request is accepted and worked, then held until the register frees.
// Depends on sfla_pkg, sfla_ctrl, sfla_dpath, sfla_ram.
module slab_free_list_allocator #(
    parameter int PAGE_BYTES  = sfla_pkg::DEF_PAGE_BYTES,
    parameter int STORE_DEPTH = sfla_pkg::DEF_STORE_DEPTH,
    parameter int ADDR_BITS   = sfla_pkg::DEF_ADDR_BITS,
    parameter int MIN_ENTRY   = sfla_pkg::DEF_MIN_ENTRY
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  sfla_pkg::req_t                  req,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output sfla_pkg::rsp_t                  rsp,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sfla_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sfla_pkg::CFG_DATA_W-1:0] cfg_data
);

    import sfla_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t sts;

    assign cfg_ready = 1'b1;

    sfla_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    sfla_dpath #(
        .PAGE_BYTES  (PAGE_BYTES),
        .STORE_DEPTH (STORE_DEPTH),
        .ADDR_BITS   (ADDR_BITS),
        .MIN_ENTRY   (MIN_ENTRY)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rsp_ready (rsp_ready),
        .cmd       (cmd),
        .sts       (sts),
        .rsp       (rsp),
        .rsp_valid (rsp_valid)
    );

endmodule

[verif/sfla_checker.sv]
// Checker for the slab free-list allocator: watches the request, response and
// register channels, keeps its own copy of the free list and compares words.
// Depends on sfla_pkg.
module sfla_checker #(
    parameter int PAGE_BYTES  = sfla_pkg::DEF_PAGE_BYTES,
    parameter int STORE_DEPTH = sfla_pkg::DEF_STORE_DEPTH,
    parameter int MIN_ENTRY   = sfla_pkg::DEF_MIN_ENTRY
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    input  logic                            req_ready,
    input  sfla_pkg::req_t                  req,
    input  logic                            rsp_valid,
    input  logic                            rsp_ready,
    input  sfla_pkg::rsp_t                  rsp,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [sfla_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sfla_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              errors,
    output int                              outstanding,
    output int                              checked,
    output int                              full_hits,
    output int                              nofit_hits,
    output int                              small_hits
);
    import sfla_pkg::*;

    logic [WORD_ADDR_W-1:0] slot_addr [STORE_DEPTH];
    int unsigned            front;
    int unsigned            count;
    logic [TOTAL_W-1:0]     carved;
    bit                     started;
    logic [ES_W-1:0]        entry_size;
    logic [HDR_W-1:0]       header_bytes;
    rsp_t                   answers_due [$];

    // appends entries of [base, base+len) behind the list; true if any dropped
    function automatic bit carve_into_list(input logic [WORD_ADDR_W-1:0] base,
                                           input int unsigned len);
        int unsigned off;
        bit          dropped;
        dropped = 1'b0;
        if (entry_size != 0) begin
            for (off = 0; off + entry_size <= len; off += entry_size) begin
                if (count >= STORE_DEPTH)
                    dropped = 1'b1;
                else
                begin
                    slot_addr[(front + count) % STORE_DEPTH] = base + off;
                    count++;
                    carved++;
                end
            end
        end
        return dropped;
    endfunction

    function automatic rsp_t predict_answer(input req_t r);
        rsp_t                   want;
        status_t                st;
        logic [WORD_ADDR_W-1:0] given;
        int unsigned            len;
        st    = ST_OK;
        given = '0;
        case (r.func)
            FUNC_START:
            begin
                if (entry_size < MIN_ENTRY)
                    st = ST_SMALL;
                else
                begin
                    len     = (header_bytes < PAGE_BYTES) ? PAGE_BYTES - header_bytes : 0;
                    front   = 0;
                    count   = 0;
                    carved  = '0;
                    started = 1'b1;
                    if (carve_into_list(r.page_base + header_bytes, len))
                        st = ST_FULL;
                end
            end
            FUNC_ALLOC:
            begin
                if (!started)
                    st = ST_NOSTART;
                else
                begin
                    if (count == 0 && carve_into_list(r.page_base, PAGE_BYTES))
                        st = ST_FULL;
                    if (count == 0)
                        st = ST_NOFIT;
                    else
                    begin
                        given = slot_addr[front];
                        front = (front + 1) % STORE_DEPTH;
                        count--;
                    end
                end
            end
            FUNC_FREE:
            begin
                if (!started)
                    st = ST_NOSTART;
                else if (count >= STORE_DEPTH)
                    st = ST_FULL;
                else
                begin
                    front = (front + STORE_DEPTH - 1) % STORE_DEPTH;
                    slot_addr[front] = r.entry_address;
                    count++;
                end
            end
            default: ;
        endcase
        case (st)
            ST_FULL:  full_hits++;
            ST_NOFIT: nofit_hits++;
            ST_SMALL: small_hits++;
            default: ;
        endcase
        want.status        = st;
        want.alloc_address = given;
        want.free_entries  = FREE_W'(count);
        want.total_entries = carved;
        return want;
    endfunction

    task automatic check_word(input rsp_t got);
        rsp_t want;
        if (answers_due.size() == 0)
        begin
            $display("%0t: unexpected response word %h", $time, got);
            errors++;
        end
        else
        begin
            want = answers_due.pop_front();
            checked++;
            if (got.status !== want.status)
            begin
                $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
                errors++;
            end
            if (got.alloc_address !== want.alloc_address)
            begin
                $display("%0t: alloc_address expected %h got %h", $time,
                         want.alloc_address, got.alloc_address);
                errors++;
            end
            if (got.free_entries !== want.free_entries)
            begin
                $display("%0t: free_entries expected %0d got %0d", $time,
                         want.free_entries, got.free_entries);
                errors++;
            end
            if (got.total_entries !== want.total_entries)
            begin
                $display("%0t: total_entries expected %0d got %0d", $time,
                         want.total_entries, got.total_entries);
                errors++;
            end
        end
    endtask

    // response first, so a stray word is never matched to a request of the same edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front        = 0;
            count        = 0;
            carved       = '0;
            started      = 1'b0;
            entry_size   = ES_RESET;
            header_bytes = HDR_RESET;
            answers_due.delete();
            outstanding <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
                check_word(rsp);
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_ENTRY_SIZE)
                    entry_size = cfg_data[ES_W-1:0];
                else if (cfg_index == CFG_HEADER_BYTES)
                    header_bytes = cfg_data[HDR_W-1:0];
            end
            if (req_valid && req_ready)
                answers_due.push_back(predict_answer(req));
            outstanding <= answers_due.size();
        end
    end

endmodule

[verif/tb_top.sv]
// Top of the slab free-list allocator testbench: clock, reset, request and
// register stimulus, response back-pressure and verdict.
// Depends on sfla_pkg, slab_free_list_allocator and sfla_checker.
module tb_top;
    import sfla_pkg::*;

    localparam int LONG_HOLD   = 300;
    localparam int IDLE_LIMIT  = 4000;
    localparam int ITEM_TARGET = 1050;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(15);

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    req_t                  req       = '0;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    rsp_t                  rsp;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int errors;
    int outstanding;
    int checked;
    int full_hits;
    int nofit_hits;
    int small_hits;
    int words_sent  = 0;
    int settings    = 0;
    int hold_asked  = 0;
    int hold_given  = 0;
    int idle_cycles = 0;
    bit calm        = 1'b0;

    slab_free_list_allocator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sfla_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding),
        .checked     (checked),
        .full_hits   (full_hits),
        .nofit_hits  (nofit_hits),
        .small_hits  (small_hits)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: watchdog, no word moved for %0d cycles", $time, IDLE_LIMIT);
            $display("status: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int unsigned pick_entry_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return $urandom_range(0, 7);
        if (r < 12)
            return $urandom_range(8, 63);
        if (r < 18)
            return $urandom_range(4097, 8191);
        if (r < 23)
            return 4096;
        return $urandom_range(64, 4095);
    endfunction

    // top bit of the data word is beyond the header register
    function automatic int unsigned pick_header();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 0;
        if (r < 25)
            return 4095;
        if (r < 32)
            return $urandom_range(4096, 8191);
        return $urandom_range(1, 4094);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic configure(input int unsigned es, input int unsigned hdr);
        write_reg(CFG_ENTRY_SIZE, es);
        write_reg(CFG_HEADER_BYTES, hdr);
        cfg_valid <= 1'b0;
        settings++;
    endtask

    task automatic send(input func_t f, input logic [31:0] page, input logic [31:0] addr);
        req_t w;
        int   gap;
        w.func          = f;
        w.page_base     = page;
        w.entry_address = addr;
        req_valid <= 1'b1;
        req       <= w;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        words_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic random_phase(input int n);
        int k;
        int r;
        send(FUNC_START, $urandom, $urandom);
        for (k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
                send(FUNC_ALLOC, $urandom, $urandom);
            else if (r < 88)
                send(FUNC_FREE, $urandom, $urandom);
            else if (r < 94)
                send(FUNC_START, $urandom, $urandom);
            else
                send(FUNC_NOP, $urandom, $urandom);
        end
    endtask

    initial
    begin : receiver
        int r;
        @(posedge clk);
        forever
        begin
            if (hold_given != hold_asked)
            begin
                hold_given++;
                rsp_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (calm)
            begin
                rsp_ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                begin
                    rsp_ready <= 1'b1;
                    repeat ($urandom_range(1, 8)) @(posedge clk);
                end
                else if (r < 95)
                begin
                    rsp_ready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge clk);
                end
                else
                begin
                    rsp_ready <= 1'b0;
                    repeat ($urandom_range(10, 40)) @(posedge clk);
                end
            end
        end
    end

    initial
    begin : stimulus
        wait (rst_n);
        @(posedge clk);

        // nothing started yet
        send(FUNC_ALLOC, 32'h0000_1000, 32'h0000_0000);
        send(FUNC_FREE, 32'h0000_0000, 32'hFFFF_FFFF);
        send(FUNC_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();
        write_reg(CFG_SPARE, 32'h1FFF);
        configure(7, 0);
        send(FUNC_START, 32'h0001_0000, 32'h0000_0000);
        send(FUNC_ALLOC, 32'h0001_0000, 32'h0000_0000);

        // header leaves a single byte, refill wraps past the top of memory
        drain();
        configure(8, 4095);
        send(FUNC_START, 32'hFFFF_F000, 32'h0000_0000);
        send(FUNC_ALLOC, 32'hFFFF_FFF8, 32'h0000_0000);
        send(FUNC_ALLOC, 32'h0000_0000, 32'h0000_0000);
        send(FUNC_FREE, 32'h0000_0000, 32'hA5A5_5A5A);
        send(FUNC_ALLOC, 32'h0000_0000, 32'h0000_0000);

        // one entry per page
        drain();
        configure(4096, 0);
        send(FUNC_START, 32'h0000_2000, 32'h0000_0000);
        send(FUNC_ALLOC, 32'h0000_0000, 32'h0000_0000);
        send(FUNC_ALLOC, 32'h0000_3000, 32'h0000_0000);

        // stride wider than a page, then zero stride
        drain();
        configure(8191, 0);
        send(FUNC_ALLOC, 32'h0000_4000, 32'h0000_0000);
        drain();
        configure(0, 0);
        send(FUNC_ALLOC, 32'h0000_5000, 32'h0000_0000);
        send(FUNC_START, 32'h0000_6000, 32'h0000_0000);
        send(FUNC_FREE, 32'h0000_0000, 32'h0000_7777);

        // restart at reset values
        drain();
        configure(16, 32);
        send(FUNC_START, 32'h0000_0000, 32'h0000_0000);
        send(FUNC_ALLOC, 32'h0000_0000, 32'h0000_0000);
        send(FUNC_FREE, 32'h0000_0000, 32'h8000_0001);
        send(FUNC_ALLOC, 32'h0000_0000, 32'h0000_0000);
        send(FUNC_NOP, 32'h0000_0000, 32'h0000_0000);

        // fill the list to the brim under a long receiver stall
        drain();
        configure(8, 0);
        calm = 1'b1;
        send(FUNC_START, $urandom, 32'h0000_0000);
        hold_asked++;
        repeat (515) send(FUNC_FREE, $urandom, $urandom);
        repeat (4) send(FUNC_ALLOC, $urandom, $urandom);
        calm = 1'b0;

        while (words_sent < ITEM_TARGET)
        begin
            drain();
            configure(pick_entry_size(), pick_header());
            calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) == 0)
                hold_asked++;
            random_phase($urandom_range(15, 60));
        end

        drain();
        repeat (10) @(posedge clk);
        $display("covered %0d request words over %0d register settings, %0d responses checked",
                 words_sent, settings, checked);
        $display("store full %0d, nothing fits %0d, entry too small %0d",
                 full_hits, nofit_hits, small_hits);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[files.f]
rtl/core/sfla_pkg.sv
rtl/core/sfla_ram.sv
rtl/core/sfla_ctrl.sv
rtl/core/sfla_dpath.sv
rtl/core/slab_free_list_allocator.sv
verif/sfla_checker.sv
verif/tb_top.sv
